// File: hdl/ufbm_pkg.sv
// Shared types and constants for the union-find bond merger.
// Holds the payload structs, the sequencer state type and fixed field widths.
// No dependencies.
package ufbm_pkg;

  // Fixed field widths
  localparam int unsigned NODE_W = 10;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned SQ_W   = 21;

  localparam logic [SQ_W-1:0] SQ_MAX         = {SQ_W{1'b1}};
  localparam logic [SQ_W-1:0] NODE_COUNT_RST = SQ_W'(1024);

  // Default store depth
  localparam int unsigned MAX_NODES_DEF = 1024;

  typedef struct packed {
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic              final_bond;
  } ufbm_in_t;

  typedef struct packed {
    logic              merged;
    logic [NODE_W-1:0] new_root;
    logic [NODE_W-1:0] largest_root;
    logic [CNT_W-1:0]  largest_size;
    logic [SQ_W-1:0]   size_square_sum;
    logic              last_result;
  } ufbm_out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_WALK_A,
    ST_WALK_B,
    ST_MERGE,
    ST_WR_ROOT,
    ST_WR_CHILD,
    ST_DONE
  } ufbm_state_e;

endpackage

// File: hdl/ufbm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; width and depth come from parameters.
module ufbm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hdl/union_find_bond_merger_top.sv
// Top level of the weighted union-find bond merger.
// Depends on ufbm_pkg (types, widths) and ufbm_ram (link store).
//
// Usage: each input beat on in_* carries one bond (node_a, node_b, final_bond).
// Both nodes are walked to their cluster roots through the link store; if the
// roots differ the larger cluster absorbs the smaller (tie: node_b's root wins).
// Each bond gives exactly one output beat on out_* with the merge flag, the
// resulting root, the largest cluster's root and size, and the saturating sum
// of squared cluster sizes. The cfg_* beat writes node_count, which re-seeds
// that sum; cfg_ready_o is always high.
// Per bond: index reduction by shifted subtracts of MAX_NODES << RED_K down
// to MAX_NODES, a root walk of each node, one parent link per step, then the
// merge and, when the roots differ, the root and child store writes (matching
// roots skip the write-back). RED_K is 0 for MAX_NODES >= 1024.
// The root walks go through the single store read port, one bond at a time:
// the next bond can be taken in the cycle after the previous result is loaded.
// Reset: the store is swept to singletons, one entry per cycle, over all
// MAX_NODES entries; in_ready_o stays low until the sweep ends.
// A stalled receiver holds the result in the output register; the next bond
// is accepted and worked on, and waits before its result is loaded.
module union_find_bond_merger_top #(
  parameter int unsigned MAX_NODES = ufbm_pkg::MAX_NODES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  ufbm_pkg::ufbm_in_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output ufbm_pkg::ufbm_out_t            out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ufbm_pkg::CNT_W-1:0]     cfg_data_i
);
  import ufbm_pkg::*;

  localparam int unsigned IDX_W    = $clog2(MAX_NODES);
  localparam int unsigned SZ_W     = $clog2(MAX_NODES + 1);
  localparam int unsigned EW       = SZ_W + 1;
  localparam int unsigned PROD_W   = 2 * SZ_W;
  localparam int unsigned SUM_W    = (PROD_W + 2 > SQ_W + 1) ? PROD_W + 2 : SQ_W + 1;
  localparam int unsigned FLOOR_LG = $clog2(MAX_NODES + 1) - 1;
  localparam int unsigned RED_K    = (MAX_NODES >= 2**NODE_W) ? 0 : NODE_W - FLOOR_LG;
  localparam int unsigned K_W      = (RED_K > 0) ? $clog2(RED_K + 1) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_NODES - 1);

  ufbm_state_e state_q, state_d;

  // Control registers
  logic [IDX_W-1:0] clr_q, clr_d;
  logic [K_W-1:0]   red_k_q, red_k_d;
  logic             out_valid_q, out_valid_d;
  logic [IDX_W-1:0] top_root_q, top_root_d;
  logic [SZ_W-1:0]  top_size_q, top_size_d;
  logic [SQ_W-1:0]  sq_q, sq_d;

  // Payload registers
  logic [NODE_W-1:0] red_a_q, red_a_d, red_b_q, red_b_d;
  logic [IDX_W-1:0]  cur_a_q, cur_a_d, cur_b_q, cur_b_d;
  logic [SZ_W-1:0]   sa_q, sa_d, sb_q, sb_d;
  logic [IDX_W-1:0]  root_q, root_d, child_q, child_d;
  logic [SZ_W-1:0]   total_q, total_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic              merged_q, merged_d;
  logic              final_q, final_d;
  ufbm_out_t         out_q, out_d;

  // Store port
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0]    ram_wdata, ram_rdata;

  logic             rd_is_root;
  logic [SZ_W-1:0]  rd_size;
  logic [IDX_W-1:0] rd_parent;
  logic [31:0]      mod_val;
  logic [SUM_W-1:0] sum_full;
  logic             out_load;

  assign rd_is_root = ram_rdata[EW-1];
  assign rd_size    = ram_rdata[SZ_W-1:0];
  assign rd_parent  = ram_rdata[IDX_W-1:0];
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  assign mod_val    = 32'(MAX_NODES) << red_k_q;

  ufbm_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_NODES)
  ) u_link_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == LAST_IDX) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_REDUCE;
      end
      ST_REDUCE: begin
        if (red_k_q == '0) state_d = ST_WALK_A;
      end
      ST_WALK_A: begin
        if (rd_is_root) state_d = ST_WALK_B;
      end
      ST_WALK_B: begin
        if (rd_is_root) state_d = ST_MERGE;
      end
      ST_MERGE: begin
        state_d = (cur_a_q == cur_b_q) ? ST_DONE : ST_WR_ROOT;
      end
      ST_WR_ROOT:  state_d = ST_WR_CHILD;
      ST_WR_CHILD: state_d = ST_DONE;
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Datapath and store control
  always_comb begin
    clr_d       = clr_q;
    red_k_d     = red_k_q;
    out_valid_d = out_valid_q && !out_ready_i;
    top_root_d  = top_root_q;
    top_size_d  = top_size_q;
    sq_d        = sq_q;
    red_a_d     = red_a_q;
    red_b_d     = red_b_q;
    cur_a_d     = cur_a_q;
    cur_b_d     = cur_b_q;
    sa_d        = sa_q;
    sb_d        = sb_q;
    root_d      = root_q;
    child_d     = child_q;
    total_d     = total_q;
    prod_d      = prod_q;
    merged_d    = merged_q;
    final_d     = final_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = clr_q;
    ram_wdata   = {1'b1, SZ_W'(1)};
    ram_raddr   = cur_a_q;
    sum_full    = SUM_W'(sq_q) + SUM_W'({prod_q, 1'b0});

    case (state_q)
      // Sweep the store to singletons
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr_q != LAST_IDX) clr_d = clr_q + 1'b1;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          red_a_d  = in_data_i.node_a;
          red_b_d  = in_data_i.node_b;
          final_d  = in_data_i.final_bond;
          red_k_d  = K_W'(RED_K);
          merged_d = 1'b0;
        end
      end
      // Index reduction modulo the depth, one shifted subtract per cycle
      ST_REDUCE: begin
        if (32'(red_a_q) >= mod_val) red_a_d = red_a_q - NODE_W'(mod_val);
        if (32'(red_b_q) >= mod_val) red_b_d = red_b_q - NODE_W'(mod_val);
        if (red_k_q != '0) begin
          red_k_d = red_k_q - 1'b1;
        end else begin
          cur_a_d   = IDX_W'(red_a_d);
          cur_b_d   = IDX_W'(red_b_d);
          ram_raddr = cur_a_d;
        end
      end
      // Root walk of node_a, one level per cycle
      ST_WALK_A: begin
        if (rd_is_root) begin
          sa_d      = rd_size;
          ram_raddr = cur_b_q;
        end else begin
          cur_a_d   = rd_parent;
          ram_raddr = rd_parent;
        end
      end
      // Root walk of node_b
      ST_WALK_B: begin
        if (rd_is_root) begin
          sb_d      = rd_size;
          ram_raddr = cur_b_q;
        end else begin
          cur_b_d   = rd_parent;
          ram_raddr = rd_parent;
        end
      end
      // Pick survivor, form size product
      ST_MERGE: begin
        root_d  = cur_b_q;
        total_d = sa_q + sb_q;
        prod_d  = PROD_W'(sa_q) * PROD_W'(sb_q);
        if (cur_a_q != cur_b_q) begin
          merged_d = 1'b1;
          if (sa_q > sb_q) begin
            root_d  = cur_a_q;
            child_d = cur_b_q;
          end else begin
            child_d = cur_a_q;
          end
        end
      end
      ST_WR_ROOT: begin
        ram_we    = 1'b1;
        ram_waddr = root_q;
        ram_wdata = {1'b1, total_q};
      end
      ST_WR_CHILD: begin
        ram_we    = 1'b1;
        ram_waddr = child_q;
        ram_wdata = {1'b0, SZ_W'(root_q)};
      end
      // Commit statistics and load the result beat
      ST_DONE: begin
        if (out_load) begin
          if (merged_q) begin
            sq_d = (sum_full > SUM_W'(SQ_MAX)) ? SQ_MAX : SQ_W'(sum_full);
            if (total_q > top_size_q) begin
              top_size_d = total_q;
              top_root_d = root_q;
            end
          end
          out_valid_d           = 1'b1;
          out_d.merged          = merged_q;
          out_d.new_root        = NODE_W'(root_q);
          out_d.largest_root    = NODE_W'(top_root_d);
          out_d.largest_size    = CNT_W'(top_size_d);
          out_d.size_square_sum = sq_d;
          out_d.last_result     = final_q;
        end
      end
      default: ;
    endcase

    // node_count write re-seeds the square sum
    if (cfg_valid_i) sq_d = SQ_W'(cfg_data_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      red_k_q     <= '0;
      out_valid_q <= 1'b0;
      top_root_q  <= '0;
      top_size_q  <= SZ_W'(1);
      sq_q        <= NODE_COUNT_RST;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      red_k_q     <= red_k_d;
      out_valid_q <= out_valid_d;
      top_root_q  <= top_root_d;
      top_size_q  <= top_size_d;
      sq_q        <= sq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    red_a_q  <= red_a_d;
    red_b_q  <= red_b_d;
    cur_a_q  <= cur_a_d;
    cur_b_q  <= cur_b_d;
    sa_q     <= sa_d;
    sb_q     <= sb_d;
    root_q   <= root_d;
    child_q  <= child_d;
    total_q  <= total_d;
    prod_q   <= prod_d;
    merged_q <= merged_d;
    final_q  <= final_d;
    out_q    <= out_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

endmodule
